// ===== rtl/bba_pkg.sv =====
// Shared constants, codes and types for the bitmap buffer allocator.
package bba_pkg;

    localparam int NUM_BUFFERS = 32;
    localparam int MAP_W       = 32;
    localparam int IDX_W       = 5;
    localparam int SLOT_W      = 8;
    localparam int CNT_W       = 6;
    localparam int TOTAL_W     = 32;
    localparam int STATUS_W    = 2;
    localparam int GRP_W       = 8;
    localparam int NUM_GRP     = MAP_W / GRP_W;
    localparam int GRP_IDX_W   = 3;

    localparam logic [MAP_W-1:0] POOL_MASK = {MAP_W{1'b1}} >> (MAP_W - NUM_BUFFERS);

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd2;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] index;
    } ffs_t;

endpackage

// ===== rtl/bba_ffs.sv =====
// Find-first-set encoder that returns the lowest set bit of the free map.
module bba_ffs
    import bba_pkg::*;
(
    input  logic [MAP_W-1:0] map,
    output ffs_t             first
);

    logic [NUM_GRP-1:0]   grp_any;
    logic [GRP_IDX_W-1:0] grp_pos [NUM_GRP];

    // Each group of eight bits is encoded on its own, then the lowest
    // non-empty group is selected.
    always_comb
    begin
        for (int g = 0; g < NUM_GRP; g++)
        begin
            grp_any[g] = |map[g*GRP_W +: GRP_W];
            grp_pos[g] = '0;
            for (int j = GRP_W - 1; j >= 0; j--)
            begin
                if (map[g*GRP_W + j])
                begin
                    grp_pos[g] = GRP_IDX_W'(j);
                end
            end
        end
    end

    always_comb
    begin
        first.found = |grp_any;
        first.index = '0;
        for (int g = NUM_GRP - 1; g >= 0; g--)
        begin
            if (grp_any[g])
            begin
                first.index = {(IDX_W - GRP_IDX_W)'(g), grp_pos[g]};
            end
        end
    end

endmodule

// ===== rtl/bitmap_buffer_allocator.sv =====
// Top level of the bitmap buffer allocator: request register, update logic, result register.
// Timing: a request accepted at a clock edge is held in the request register, and its result
// is then written to the result register together with the result strobe.
// Throughput: one request per cycle; busy is never raised, and the free-map update
// through the find-first-set encoder is combinational.
// Reset: all slots free, all totals and usage counts zero, no result pending.
// The receiver cannot stall, so each result is shown for exactly one cycle.
module bitmap_buffer_allocator
    import bba_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                opcode,
    input  logic [SLOT_W-1:0]   slot_index,
    output logic                done,
    output logic [STATUS_W-1:0] status,
    output logic [IDX_W-1:0]    granted_slot,
    output logic [TOTAL_W-1:0]  alloc_total,
    output logic [TOTAL_W-1:0]  free_total,
    output logic [CNT_W-1:0]    peak_in_use,
    output logic [CNT_W-1:0]    now_in_use
);

    logic               req_valid_reg;
    logic               op_reg;
    logic [SLOT_W-1:0]  idx_reg;

    logic [MAP_W-1:0]   free_map_reg,   free_map_next;
    logic [TOTAL_W-1:0] alloc_cnt_reg,  alloc_cnt_next;
    logic [TOTAL_W-1:0] free_cnt_reg,   free_cnt_next;
    logic [CNT_W-1:0]   peak_reg,       peak_next;
    logic [CNT_W-1:0]   usage_reg,      usage_next;

    logic                done_reg;
    logic [STATUS_W-1:0] status_reg,    status_next;
    logic [IDX_W-1:0]    granted_reg,   granted_next;

    logic [MAP_W-1:0]   avail;
    ffs_t               first;
    logic [CNT_W-1:0]   usage_inc;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            op_reg  <= opcode;
            idx_reg <= slot_index;
        end
    end

    assign avail = free_map_reg & POOL_MASK;

    bba_ffs u_ffs
    (
        .map   (avail),
        .first (first)
    );

    assign usage_inc = usage_reg + CNT_W'(1);

    always_comb
    begin
        free_map_next  = free_map_reg;
        alloc_cnt_next = alloc_cnt_reg;
        free_cnt_next  = free_cnt_reg;
        peak_next      = peak_reg;
        usage_next     = usage_reg;
        status_next    = ST_DONE;
        granted_next   = '0;
        if (op_reg == OP_ALLOC)
        begin
            if (!first.found)
            begin
                status_next = ST_EXHAUSTED;
            end
            else
            begin
                granted_next   = first.index;
                free_map_next  = free_map_reg & ~(MAP_W'(1) << first.index);
                alloc_cnt_next = alloc_cnt_reg + TOTAL_W'(1);
                usage_next     = usage_inc;
                if (usage_inc > peak_reg)
                begin
                    peak_next = usage_inc;
                end
            end
        end
        else
        begin
            if (idx_reg >= SLOT_W'(NUM_BUFFERS))
            begin
                status_next = ST_BAD_INDEX;
            end
            else
            begin
                free_map_next = free_map_reg | (MAP_W'(1) << idx_reg[IDX_W-1:0]);
                free_cnt_next = free_cnt_reg + TOTAL_W'(1);
                if (usage_reg != '0)
                begin
                    usage_next = usage_reg - CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_map_reg  <= POOL_MASK;
            alloc_cnt_reg <= '0;
            free_cnt_reg  <= '0;
            peak_reg      <= '0;
            usage_reg     <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            done_reg <= req_valid_reg;
            if (req_valid_reg)
            begin
                free_map_reg  <= free_map_next;
                alloc_cnt_reg <= alloc_cnt_next;
                free_cnt_reg  <= free_cnt_next;
                peak_reg      <= peak_next;
                usage_reg     <= usage_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid_reg)
        begin
            status_reg  <= status_next;
            granted_reg <= granted_next;
        end
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign granted_slot = granted_reg;
    assign alloc_total  = alloc_cnt_reg;
    assign free_total   = free_cnt_reg;
    assign peak_in_use  = peak_reg;
    assign now_in_use   = usage_reg;

endmodule
